>>> hdl/vda_pkg.sv
// ----------------------------------------------------------------------------
// vda_pkg
// Shared types, codes and helpers of the 2D vector arithmetic unit.
// ----------------------------------------------------------------------------
package vda_pkg;

    localparam int DEF_FRAC_BITS = 16;
    localparam int WORD_W        = 32;
    localparam int ROOT_STEPS    = 32;

    typedef enum logic [2:0] {
        ACT_ADD  = 3'd0,
        ACT_SUB  = 3'd1,
        ACT_SCL  = 3'd2,
        ACT_LEN  = 3'd3,
        ACT_NORM = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SAT  = 2'd1,
        ST_ZERO = 2'd2,
        ST_BAD  = 2'd3
    } t_status;

    // Item context carried down the cell chain
    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] a_x;
        logic [31:0] a_y;
        logic [31:0] r_x;
        logic [31:0] r_y;
        logic        sat;
    } t_item;

    // Saturate a 33-bit sum to 32 bits; bit 32 of the result flags saturation
    function automatic logic [32:0] f_sat33(input logic signed [32:0] v);
        logic [32:0] res;
        res = {1'b0, v[31:0]};
        if (v[32] != v[31]) begin
            res = v[32] ? {1'b1, 32'h8000_0000} : {1'b1, 32'h7FFF_FFFF};
        end
        return res;
    endfunction

    // Saturate a 64-bit value to 32 bits; bit 32 of the result flags saturation
    function automatic logic [32:0] f_sat64(input logic signed [63:0] v);
        logic [32:0] res;
        res = {1'b0, v[31:0]};
        if (v > 64'sh0000_0000_7FFF_FFFF) begin
            res = {1'b1, 32'h7FFF_FFFF};
        end else if (v < -64'sh0000_0000_8000_0000) begin
            res = {1'b1, 32'h8000_0000};
        end
        return res;
    endfunction

endpackage

>>> hdl/vda_sqrt_cell.sv
// ----------------------------------------------------------------------------
// vda_sqrt_cell
// One digit step of the integer square root: settles one root bit a cycle while i_adv is high.
// ----------------------------------------------------------------------------
module vda_sqrt_cell import vda_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_adv,
    input  logic        i_valid,
    input  t_item       i_item,
    input  logic [63:0] i_num,
    input  logic [33:0] i_rem,
    input  logic [31:0] i_root,
    output logic        o_valid,
    output t_item       o_item,
    output logic [63:0] o_num,
    output logic [33:0] o_rem,
    output logic [31:0] o_root
);

    logic        r_valid;
    t_item       r_item;
    logic [63:0] r_num;
    logic [33:0] r_rem, n_rem;
    logic [31:0] r_root, n_root;
    logic [33:0] w_part;
    logic [33:0] w_trial;

    always_comb begin
        w_part  = {i_rem[31:0], i_num[63:62]};
        w_trial = {i_root, 2'b01};
        if (w_part >= w_trial) begin
            n_rem  = w_part - w_trial;
            n_root = {i_root[30:0], 1'b1};
        end else begin
            n_rem  = w_part;
            n_root = {i_root[30:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_item <= i_item;
            r_num  <= {i_num[61:0], 2'b00};
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
    assign o_num   = r_num;
    assign o_rem   = r_rem;
    assign o_root  = r_root;

endmodule

>>> hdl/vda_div_cell.sv
// ----------------------------------------------------------------------------
// vda_div_cell
// One restoring division step for both components: one quotient bit a cycle while i_adv is high.
// ----------------------------------------------------------------------------
module vda_div_cell import vda_pkg::*; #(
    parameter int QW    = DEF_FRAC_BITS + 1,
    parameter bit FIRST = 1'b0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_adv,
    input  logic          i_valid,
    input  t_item         i_item,
    input  logic [31:0]   i_len,
    input  logic [32:0]   i_rem_x,
    input  logic [32:0]   i_rem_y,
    input  logic [QW-1:0] i_q_x,
    input  logic [QW-1:0] i_q_y,
    output logic          o_valid,
    output t_item         o_item,
    output logic [31:0]   o_len,
    output logic [32:0]   o_rem_x,
    output logic [32:0]   o_rem_y,
    output logic [QW-1:0] o_q_x,
    output logic [QW-1:0] o_q_y
);

    logic          r_valid;
    t_item         r_item;
    logic [31:0]   r_len;
    logic [32:0]   r_rem_x, r_rem_y, n_rem_x, n_rem_y;
    logic [QW-1:0] r_q_x, r_q_y, n_q_x, n_q_y;
    logic [32:0]   w_px, w_py, w_len;

    always_comb begin
        // first step takes the whole part, later steps shift in a zero bit
        w_px  = FIRST ? i_rem_x : {i_rem_x[31:0], 1'b0};
        w_py  = FIRST ? i_rem_y : {i_rem_y[31:0], 1'b0};
        w_len = {1'b0, i_len};
        n_rem_x = w_px;
        n_rem_y = w_py;
        n_q_x   = {i_q_x[QW-2:0], 1'b0};
        n_q_y   = {i_q_y[QW-2:0], 1'b0};
        if (w_px >= w_len) begin
            n_rem_x  = w_px - w_len;
            n_q_x[0] = 1'b1;
        end
        if (w_py >= w_len) begin
            n_rem_y  = w_py - w_len;
            n_q_y[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_item  <= i_item;
            r_len   <= i_len;
            r_rem_x <= n_rem_x;
            r_rem_y <= n_rem_y;
            r_q_x   <= n_q_x;
            r_q_y   <= n_q_y;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
    assign o_len   = r_len;
    assign o_rem_x = r_rem_x;
    assign o_rem_y = r_rem_y;
    assign o_q_x   = r_q_x;
    assign o_q_y   = r_q_y;

endmodule

>>> hdl/vector2d_alu.sv
// ----------------------------------------------------------------------------
// vector2d_alu
// Pipelined 2D vector unit: add, subtract, scale, length and normalize.
// ----------------------------------------------------------------------------
//  channel   | dir | fields (low bit up)
//  s_axis    | in  | tuser: action; tdata: a_x, a_y, b_x, b_y, scalar
//  m_axis    | out | tdata: result_x, result_y, magnitude, status, zero pad
//
//  Takes one beat per cycle while the output is not stalled. The chain is two
//  front stages (multipliers and raw sums, then saturation and sum of squares),
//  32 square root cells, FRAC_BITS + 1 divider cells and the output register.
//  The whole chain advances together; it holds while a result beat waits
//  at a stalled output. Reset clears all valid bits; no clearing pass.
// ----------------------------------------------------------------------------
module vector2d_alu import vda_pkg::*; #(
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [2:0]   s_axis_tuser,   // action
    input  logic [159:0] s_axis_tdata,   // a_x, a_y, b_x, b_y, scalar
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [103:0] m_axis_tdata    // result_x, result_y, magnitude, status
);

    localparam int QW = FRAC_BITS + 1;
    localparam int DN = FRAC_BITS + 1;

    // global advance: move the chain whenever the output slot can take a beat
    logic w_adv;
    logic r_out_valid;
    assign w_adv         = !r_out_valid || m_axis_tready;
    assign s_axis_tready = w_adv;

    // ---------------- stage 1: multipliers and raw sums ----------------
    logic [31:0] w_ax, w_ay, w_bx, w_by, w_sc;
    logic [31:0] w_abs_x, w_abs_y;
    assign w_ax = s_axis_tdata[31:0];
    assign w_ay = s_axis_tdata[63:32];
    assign w_bx = s_axis_tdata[95:64];
    assign w_by = s_axis_tdata[127:96];
    assign w_sc = s_axis_tdata[159:128];
    assign w_abs_x = w_ax[31] ? (32'd0 - w_ax) : w_ax;
    assign w_abs_y = w_ay[31] ? (32'd0 - w_ay) : w_ay;

    logic               r_v1;
    logic [2:0]         r1_action;
    logic [31:0]        r1_ax, r1_ay;
    logic signed [32:0] r1_sx, r1_sy;
    logic signed [63:0] r1_px, r1_py;
    logic [63:0]        r1_qx, r1_qy;
    logic signed [32:0] w_ext_ax, w_ext_ay, w_ext_bx, w_ext_by;

    assign w_ext_ax = $signed({w_ax[31], w_ax});
    assign w_ext_ay = $signed({w_ay[31], w_ay});
    assign w_ext_bx = $signed({w_bx[31], w_bx});
    assign w_ext_by = $signed({w_by[31], w_by});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_action <= s_axis_tuser;
            r1_ax     <= w_ax;
            r1_ay     <= w_ay;
            // subtract shares the adder slot; pick by action
            r1_sx     <= (s_axis_tuser == ACT_SUB) ? (w_ext_ax - w_ext_bx)
                                                   : (w_ext_ax + w_ext_bx);
            r1_sy     <= (s_axis_tuser == ACT_SUB) ? (w_ext_ay - w_ext_by)
                                                   : (w_ext_ay + w_ext_by);
            r1_px     <= $signed(w_ax) * $signed(w_sc);
            r1_py     <= $signed(w_ay) * $signed(w_sc);
            r1_qx     <= w_abs_x * w_abs_x;
            r1_qy     <= w_abs_y * w_abs_y;
        end
    end

    // ---------------- stage 2: saturation and sum of squares -------------
    logic        r_v2;
    t_item       r2_item, w_item2;
    logic [63:0] r2_num;
    logic [32:0] w_sat_ax, w_sat_ay, w_sat_px, w_sat_py;

    assign w_sat_ax = f_sat33(r1_sx);
    assign w_sat_ay = f_sat33(r1_sy);
    assign w_sat_px = f_sat64(r1_px >>> FRAC_BITS);
    assign w_sat_py = f_sat64(r1_py >>> FRAC_BITS);

    always_comb begin
        w_item2.action = r1_action;
        w_item2.a_x    = r1_ax;
        w_item2.a_y    = r1_ay;
        if (r1_action == ACT_SCL) begin
            w_item2.r_x = w_sat_px[31:0];
            w_item2.r_y = w_sat_py[31:0];
            w_item2.sat = w_sat_px[32] | w_sat_py[32];
        end else begin
            w_item2.r_x = w_sat_ax[31:0];
            w_item2.r_y = w_sat_ay[31:0];
            w_item2.sat = w_sat_ax[32] | w_sat_ay[32];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_adv) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2_item <= w_item2;
            r2_num  <= r1_qx + r1_qy;
        end
    end

    // ---------------- square root chain ----------------------------------
    logic        sq_valid [0:ROOT_STEPS];
    t_item       sq_item  [0:ROOT_STEPS];
    logic [63:0] sq_num   [0:ROOT_STEPS];
    logic [33:0] sq_rem   [0:ROOT_STEPS];
    logic [31:0] sq_root  [0:ROOT_STEPS];

    assign sq_valid[0] = r_v2;
    assign sq_item[0]  = r2_item;
    assign sq_num[0]   = r2_num;
    assign sq_rem[0]   = 34'd0;
    assign sq_root[0]  = 32'd0;

    for (genvar g = 0; g < ROOT_STEPS; g++) begin : g_sqrt
        vda_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_valid (sq_valid[g]),
            .i_item  (sq_item[g]),
            .i_num   (sq_num[g]),
            .i_rem   (sq_rem[g]),
            .i_root  (sq_root[g]),
            .o_valid (sq_valid[g+1]),
            .o_item  (sq_item[g+1]),
            .o_num   (sq_num[g+1]),
            .o_rem   (sq_rem[g+1]),
            .o_root  (sq_root[g+1])
        );
    end

    // ---------------- divider chain --------------------------------------
    logic          dv_valid [0:DN];
    t_item         dv_item  [0:DN];
    logic [31:0]   dv_len   [0:DN];
    logic [32:0]   dv_rem_x [0:DN];
    logic [32:0]   dv_rem_y [0:DN];
    logic [QW-1:0] dv_q_x   [0:DN];
    logic [QW-1:0] dv_q_y   [0:DN];
    logic [31:0]   w_mx, w_my;

    assign w_mx = sq_item[ROOT_STEPS].a_x[31] ? (32'd0 - sq_item[ROOT_STEPS].a_x)
                                              : sq_item[ROOT_STEPS].a_x;
    assign w_my = sq_item[ROOT_STEPS].a_y[31] ? (32'd0 - sq_item[ROOT_STEPS].a_y)
                                              : sq_item[ROOT_STEPS].a_y;

    assign dv_valid[0] = sq_valid[ROOT_STEPS];
    assign dv_item[0]  = sq_item[ROOT_STEPS];
    assign dv_len[0]   = sq_root[ROOT_STEPS];
    assign dv_rem_x[0] = {1'b0, w_mx};
    assign dv_rem_y[0] = {1'b0, w_my};
    assign dv_q_x[0]   = '0;
    assign dv_q_y[0]   = '0;

    for (genvar g = 0; g < DN; g++) begin : g_div
        vda_div_cell #(
            .QW    (QW),
            .FIRST (g == 0)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_valid (dv_valid[g]),
            .i_item  (dv_item[g]),
            .i_len   (dv_len[g]),
            .i_rem_x (dv_rem_x[g]),
            .i_rem_y (dv_rem_y[g]),
            .i_q_x   (dv_q_x[g]),
            .i_q_y   (dv_q_y[g]),
            .o_valid (dv_valid[g+1]),
            .o_item  (dv_item[g+1]),
            .o_len   (dv_len[g+1]),
            .o_rem_x (dv_rem_x[g+1]),
            .o_rem_y (dv_rem_y[g+1]),
            .o_q_x   (dv_q_x[g+1]),
            .o_q_y   (dv_q_y[g+1])
        );
    end

    // ---------------- result assembly and output register ----------------
    t_item       w_fi;
    logic [31:0] w_len, w_qx, w_qy;
    logic [31:0] n_rx, n_ry;
    logic [30:0] n_mag;
    logic [1:0]  n_status;
    logic [31:0] r_rx, r_ry;
    logic [30:0] r_mag;
    logic [1:0]  r_status;

    assign w_fi  = dv_item[DN];
    assign w_len = dv_len[DN];
    assign w_qx  = 32'(dv_q_x[DN]);
    assign w_qy  = 32'(dv_q_y[DN]);

    always_comb begin
        n_rx     = 32'd0;
        n_ry     = 32'd0;
        n_mag    = 31'd0;
        n_status = ST_OK;
        unique case (w_fi.action)
            ACT_ADD, ACT_SUB, ACT_SCL: begin
                n_rx     = w_fi.r_x;
                n_ry     = w_fi.r_y;
                n_status = w_fi.sat ? ST_SAT : ST_OK;
            end
            ACT_LEN: begin
                // clamp roots above the 31-bit range
                if (w_len[31]) begin
                    n_mag    = 31'h7FFF_FFFF;
                    n_status = ST_SAT;
                end else begin
                    n_mag = w_len[30:0];
                end
            end
            ACT_NORM: begin
                if (w_len == 32'd0) begin
                    n_status = ST_ZERO;
                end else begin
                    n_rx = w_fi.a_x[31] ? (32'd0 - w_qx) : w_qx;
                    n_ry = w_fi.a_y[31] ? (32'd0 - w_qy) : w_qy;
                end
            end
            default: begin
                n_status = ST_BAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= dv_valid[DN];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_rx     <= n_rx;
            r_ry     <= n_ry;
            r_mag    <= n_mag;
            r_status <= n_status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_status, r_mag, r_ry, r_rx};

`ifndef ASSERT_OFF
    // zero-vector normalize must never leave a nonzero component
    a_zero_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == ST_ZERO) |-> (r_rx == 32'd0 && r_ry == 32'd0
                                                  && r_mag == 31'd0))
        else $error("zero-vector result carries data");

    // a length result carries no vector part
    a_len_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_mag != 31'd0) |-> (r_rx == 32'd0 && r_ry == 32'd0))
        else $error("magnitude and vector both set");

    // a stalled output freezes the whole chain
    a_chain_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |=> $stable(dv_valid[DN]) && $stable(r_v1))
        else $error("chain moved during stall");
`endif

endmodule
